// File: rtl/wrpr_pkg.sv
// ----------------------------------------------------------------------------
// wrpr_pkg
// Shared types, codes and the mu-law expansion for the WAV parser block.
// ----------------------------------------------------------------------------
package wrpr_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [15:0] FMT_PCM   = 16'd1;
    localparam logic [15:0] FMT_MULAW = 16'd7;

    localparam logic [2:0] KIND_FORMAT = 3'd0;
    localparam logic [2:0] KIND_PCM    = 3'd1;
    localparam logic [2:0] KIND_MULAW  = 3'd2;
    localparam logic [2:0] KIND_ERROR  = 3'd3;
    localparam logic [2:0] KIND_DONE   = 3'd4;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_RIFF  = 3'd1;
    localparam logic [2:0] ERR_BAD_WAVE  = 3'd2;
    localparam logic [2:0] ERR_FMT_SHORT = 3'd3;
    localparam logic [2:0] ERR_FORMAT    = 3'd4;
    localparam logic [2:0] ERR_NO_FMT    = 3'd5;
    localparam logic [2:0] ERR_TRUNC     = 3'd6;

    // One queue entry holds every result that a single input byte causes.
    // A second result is always either a done marker or a truncation error.
    typedef struct packed {
        logic        two;
        logic        second_done;
        logic [2:0]  kind;
        logic [2:0]  err;
        logic [7:0]  data_byte;
        logic [15:0] channels;
        logic [15:0] bits;
        logic [31:0] rate;
    } wrpr_entry_t;

    function automatic logic [15:0] mu_base(input logic [2:0] e);
        logic [15:0] b;
        unique case (e)
            3'd0: b = 16'd0;
            3'd1: b = 16'd132;
            3'd2: b = 16'd396;
            3'd3: b = 16'd924;
            3'd4: b = 16'd1980;
            3'd5: b = 16'd4092;
            3'd6: b = 16'd8316;
            3'd7: b = 16'd16764;
        endcase
        return b;
    endfunction

    function automatic logic [15:0] mulaw_expand(input logic [7:0] code);
        logic [7:0]  v;
        logic [15:0] mag;
        v   = ~code;
        mag = mu_base(v[6:4]) + (16'(v[3:0]) << ({1'b0, v[6:4]} + 4'd3));
        if (v[7]) begin
            mag = 16'd0 - mag;
        end
        return mag;
    endfunction

endpackage

// File: rtl/wav_riff_parser_mulaw_expand_unit.sv
// ----------------------------------------------------------------------------
// wav_riff_parser_mulaw_expand_unit
// Streaming WAV parser with mu-law expansion to 16-bit linear samples.
// ----------------------------------------------------------------------------
// The block takes one file byte per cycle on the input stream and places the
// results of each byte, if any, in a queue of QUEUE_DEPTH entries. The output
// register delivers one result per cycle while the consumer is ready, and each
// result is one output transfer, so the rare byte with two results (a data byte
// followed by the done marker, or a result followed by a truncation error)
// takes two transfers. Input stalls only when the queue is full; the first result
// of a byte is written into the queue and then loaded into the output register,
// which holds it until it is taken.
module wav_riff_parser_mulaw_expand_unit import wrpr_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [2:0] error_code, [18:3] channel_count,
                                   // [34:19] bits_per_sample, [66:35] sample_rate,
                                   // [74:67] pcm_byte, [90:75] linear_sample,
                                   // [95:91] zero
    output logic [2:0]  m_tuser,   // [2:0] result_kind
    output logic        m_tlast    // last_of_run
);

    logic        q_push, q_full, q_pop, q_valid;
    wrpr_entry_t q_in, q_head;
    logic [2:0]  err;
    logic [15:0] chan, bits, lin;
    logic [31:0] rate;
    logic [7:0]  pcm;

    wrpr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_eof   (s_tlast),
        .q_push   (q_push),
        .q_entry  (q_in),
        .q_full   (q_full)
    );

    wrpr_fifo #(.DEPTH(DEPTH)) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    wrpr_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_kind     (m_tuser),
        .out_err      (err),
        .out_channels (chan),
        .out_bits     (bits),
        .out_rate     (rate),
        .out_pcm      (pcm),
        .out_linear   (lin),
        .out_last     (m_tlast)
    );

    assign m_tdata = {5'b0, lin, pcm, rate, bits, chan, err};

endmodule

// File: rtl/wrpr_front.sv
// ----------------------------------------------------------------------------
// wrpr_front
// Byte-wise RIFF/WAVE chunk parser. Takes one byte a cycle while the queue is
// not full and queues the results that each byte causes as a single entry.
// ----------------------------------------------------------------------------
module wrpr_front import wrpr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_eof,
    output logic        q_push,
    output wrpr_entry_t q_entry,
    input  logic        q_full
);

    localparam logic [3:0] PH_RIFF       = 4'd0;
    localparam logic [3:0] PH_RIFF_SIZE  = 4'd1;
    localparam logic [3:0] PH_WAVE       = 4'd2;
    localparam logic [3:0] PH_CHUNK_TAG  = 4'd3;
    localparam logic [3:0] PH_CHUNK_SIZE = 4'd4;
    localparam logic [3:0] PH_FMT_BODY   = 4'd5;
    localparam logic [3:0] PH_SKIP       = 4'd6;
    localparam logic [3:0] PH_DATA       = 4'd7;
    localparam logic [3:0] PH_HALT       = 4'd8;

    logic [3:0]  phase_reg, phase_next;
    logic [1:0]  biw_reg, biw_next;
    logic [23:0] gather_reg, gather_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] left_reg, left_next;
    logic [15:0] fcode_reg, fcode_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic        seen_reg, seen_next;
    logic [1:0]  fword_reg, fword_next;

    logic        accept;
    logic [31:0] word;
    logic        first_v;
    logic        second_v;
    wrpr_entry_t ent;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign word     = {in_byte, gather_reg};

    always_comb begin
        phase_next  = phase_reg;
        biw_next    = biw_reg;
        gather_next = gather_reg;
        tag_next    = tag_reg;
        left_next   = left_reg;
        fcode_next  = fcode_reg;
        chan_next   = chan_reg;
        rate_next   = rate_reg;
        bits_next   = bits_reg;
        seen_next   = seen_reg;
        fword_next  = fword_reg;
        first_v     = 1'b0;
        second_v    = 1'b0;
        ent         = '0;
        ent.channels  = chan_reg;
        ent.bits      = bits_reg;
        ent.rate      = rate_reg;
        ent.data_byte = in_byte;

        if (phase_reg <= PH_FMT_BODY) begin
            if (biw_reg != 2'd3) begin
                unique case (biw_reg)
                    2'd0:    gather_next[7:0]   = in_byte;
                    2'd1:    gather_next[15:8]  = in_byte;
                    default: gather_next[23:16] = in_byte;
                endcase
                biw_next = biw_reg + 2'd1;
            end else begin
                biw_next    = 2'd0;
                gather_next = '0;
                unique case (phase_reg)
                    PH_RIFF: begin
                        if (word != TAG_RIFF) begin
                            first_v = 1'b1; ent.kind = KIND_ERROR;
                            ent.err = ERR_BAD_RIFF; phase_next = PH_HALT;
                        end else begin
                            phase_next = PH_RIFF_SIZE;
                        end
                    end
                    PH_RIFF_SIZE: phase_next = PH_WAVE;
                    PH_WAVE: begin
                        if (word != TAG_WAVE) begin
                            first_v = 1'b1; ent.kind = KIND_ERROR;
                            ent.err = ERR_BAD_WAVE; phase_next = PH_HALT;
                        end else begin
                            phase_next = PH_CHUNK_TAG;
                        end
                    end
                    PH_CHUNK_TAG: begin
                        tag_next   = word;
                        phase_next = PH_CHUNK_SIZE;
                    end
                    PH_CHUNK_SIZE: begin
                        if (tag_reg == TAG_FMT) begin
                            if (word < 32'd16) begin
                                first_v = 1'b1; ent.kind = KIND_ERROR;
                                ent.err = ERR_FMT_SHORT; phase_next = PH_HALT;
                            end else begin
                                left_next  = word - 32'd16;
                                fword_next = 2'd0;
                                phase_next = PH_FMT_BODY;
                            end
                        end else if (tag_reg == TAG_DATA) begin
                            if (!seen_reg) begin
                                first_v = 1'b1; ent.kind = KIND_ERROR;
                                ent.err = ERR_NO_FMT; phase_next = PH_HALT;
                            end else begin
                                first_v   = 1'b1;
                                ent.kind  = KIND_FORMAT;
                                left_next = word;
                                if (word == 32'd0) begin
                                    second_v        = 1'b1;
                                    ent.second_done = 1'b1;
                                    phase_next      = PH_HALT;
                                end else begin
                                    phase_next = PH_DATA;
                                end
                            end
                        end else begin
                            left_next  = word;
                            phase_next = (word != 32'd0) ? PH_SKIP : PH_CHUNK_TAG;
                        end
                    end
                    default: begin
                        fword_next = fword_reg + 2'd1;
                        unique case (fword_reg)
                            2'd0: begin
                                fcode_next = word[15:0];
                                chan_next  = word[31:16];
                            end
                            2'd1: rate_next = word;
                            2'd2: ;
                            2'd3: begin
                                if (fcode_reg != FMT_PCM && fcode_reg != FMT_MULAW) begin
                                    bits_next  = word[31:16];
                                    first_v    = 1'b1;
                                    ent.kind   = KIND_ERROR;
                                    ent.err    = ERR_FORMAT;
                                    phase_next = PH_HALT;
                                end else begin
                                    bits_next  = (fcode_reg == FMT_MULAW) ?
                                                 {word[30:16], 1'b0} : word[31:16];
                                    seen_next  = 1'b1;
                                    phase_next = (left_reg != 32'd0) ? PH_SKIP
                                                                      : PH_CHUNK_TAG;
                                end
                            end
                        endcase
                    end
                endcase
            end
        end else if (phase_reg == PH_SKIP) begin
            left_next = left_reg - 32'd1;
            if (left_reg == 32'd1) begin
                phase_next = PH_CHUNK_TAG;
            end
        end else if (phase_reg == PH_DATA) begin
            first_v   = 1'b1;
            ent.kind  = (fcode_reg == FMT_MULAW) ? KIND_MULAW : KIND_PCM;
            left_next = left_reg - 32'd1;
            if (left_reg == 32'd1) begin
                second_v        = 1'b1;
                ent.second_done = 1'b1;
                phase_next      = PH_HALT;
            end
        end

        if (in_eof) begin
            if (phase_next != PH_HALT && !second_v) begin
                if (!first_v) begin
                    first_v  = 1'b1;
                    ent.kind = KIND_ERROR;
                    ent.err  = ERR_TRUNC;
                end else begin
                    second_v        = 1'b1;
                    ent.second_done = 1'b0;
                end
            end
            phase_next  = PH_RIFF;
            biw_next    = '0;
            gather_next = '0;
            tag_next    = '0;
            left_next   = '0;
            fcode_next  = '0;
            chan_next   = '0;
            rate_next   = '0;
            bits_next   = '0;
            seen_next   = 1'b0;
            fword_next  = '0;
        end
        ent.two = second_v;
    end

    assign q_push  = accept && first_v;
    assign q_entry = ent;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_RIFF;
            biw_reg    <= '0;
            gather_reg <= '0;
            tag_reg    <= '0;
            left_reg   <= '0;
            fcode_reg  <= '0;
            chan_reg   <= '0;
            rate_reg   <= '0;
            bits_reg   <= '0;
            seen_reg   <= 1'b0;
            fword_reg  <= '0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            biw_reg    <= biw_next;
            gather_reg <= gather_next;
            tag_reg    <= tag_next;
            left_reg   <= left_next;
            fcode_reg  <= fcode_next;
            chan_reg   <= chan_next;
            rate_reg   <= rate_next;
            bits_reg   <= bits_next;
            seen_reg   <= seen_next;
            fword_reg  <= fword_next;
        end
    end

endmodule

// File: rtl/wrpr_fifo.sv
// ----------------------------------------------------------------------------
// wrpr_fifo
// Short first-in first-out queue of parser entries between front and back.
// ----------------------------------------------------------------------------
module wrpr_fifo import wrpr_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  wrpr_entry_t push_data,
    output logic        full,
    input  logic        pop,
    output logic        not_empty,
    output wrpr_entry_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    wrpr_entry_t   slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/wrpr_back.sv
// ----------------------------------------------------------------------------
// wrpr_back
// Unpacks queued entries into result items, expands mu-law codes and holds
// each result in the output register until it is taken.
// ----------------------------------------------------------------------------
module wrpr_back import wrpr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  wrpr_entry_t q_head,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_kind,
    output logic [2:0]  out_err,
    output logic [15:0] out_channels,
    output logic [15:0] out_bits,
    output logic [31:0] out_rate,
    output logic [7:0]  out_pcm,
    output logic [15:0] out_linear,
    output logic        out_last
);

    logic        valid_reg;
    logic        sub_reg, sub_next;
    logic        load;
    logic [2:0]  kind_reg, kind_next;
    logic [2:0]  err_reg, err_next;
    logic [15:0] chan_reg, chan_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] rate_reg, rate_next;
    logic [7:0]  pcm_reg, pcm_next;
    logic [15:0] lin_reg, lin_next;
    logic        last_reg, last_next;

    assign load = q_valid && (!valid_reg || out_ready);

    always_comb begin
        kind_next = q_head.kind;
        err_next  = '0;
        chan_next = '0;
        bits_next = '0;
        rate_next = '0;
        pcm_next  = '0;
        lin_next  = '0;
        last_next = 1'b1;
        sub_next  = 1'b0;
        q_pop     = load;
        if (sub_reg) begin
            kind_next = q_head.second_done ? KIND_DONE : KIND_ERROR;
            err_next  = q_head.second_done ? ERR_NONE : ERR_TRUNC;
        end else begin
            unique case (q_head.kind)
                KIND_FORMAT: begin
                    chan_next = q_head.channels;
                    bits_next = q_head.bits;
                    rate_next = q_head.rate;
                end
                KIND_PCM:   pcm_next = q_head.data_byte;
                KIND_MULAW: lin_next = mulaw_expand(q_head.data_byte);
                KIND_ERROR: err_next = q_head.err;
                default:    ;
            endcase
            if (q_head.two) begin
                last_next = 1'b0;
                sub_next  = 1'b1;
                q_pop     = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sub_reg   <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
            sub_reg   <= sub_next;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg <= kind_next;
            err_reg  <= err_next;
            chan_reg <= chan_next;
            bits_reg <= bits_next;
            rate_reg <= rate_next;
            pcm_reg  <= pcm_next;
            lin_reg  <= lin_next;
            last_reg <= last_next;
        end
    end

    assign out_valid    = valid_reg;
    assign out_kind     = kind_reg;
    assign out_err      = err_reg;
    assign out_channels = chan_reg;
    assign out_bits     = bits_reg;
    assign out_rate     = rate_reg;
    assign out_pcm      = pcm_reg;
    assign out_linear   = lin_reg;
    assign out_last     = last_reg;

endmodule

// File: rtl/wrpr_checker.sv
// ----------------------------------------------------------------------------
// wrpr_checker
// Port-level checks on the result stream of the WAV parser block.
// ----------------------------------------------------------------------------
module wrpr_checker import wrpr_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == KIND_FORMAT || m_tuser == KIND_PCM ||
                      m_tuser == KIND_MULAW || m_tuser == KIND_ERROR ||
                      m_tuser == KIND_DONE))
        else $error("result kind out of range");

    a_err_only_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != KIND_ERROR) |-> (m_tdata[2:0] == ERR_NONE))
        else $error("error code on a non-error result");

    a_format_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != KIND_FORMAT) |-> (m_tdata[66:3] == '0))
        else $error("format fields set on a non-format result");

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_DONE || m_tuser == KIND_ERROR)) |-> m_tlast)
        else $error("done or error result not last of its run");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind wav_riff_parser_mulaw_expand_unit wrpr_checker u_wrpr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming WAV parser with mu-law expansion.
// ----------------------------------------------------------------------------
// Whole WAV files are sent one byte per request: first a handful of hand-built
// files covering each error, the empty data chunk, repeated and padded fmt
// chunks and the mu-law extremes, then randomly shaped files. A parser model
// in the bench predicts every result, and the monitor compares each accepted
// result field by field. Sender and receiver idle in rotating phases.
// ----------------------------------------------------------------------------
module tb_top;
    import wrpr_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_BYTES  = 80;
    localparam int PHASE_SPAN    = 48;
    localparam int DRAIN_CYCLES  = 20;

    typedef enum logic [3:0] {
        AWAIT_RIFF, AWAIT_RIFF_SIZE, AWAIT_WAVE, AWAIT_TAG, AWAIT_SIZE,
        IN_FMT, SKIPPING, IN_DATA, HALTED
    } parse_state_t;

    typedef struct {
        logic [7:0] value;
        logic       eof;
    } file_byte_t;

    typedef struct {
        logic [2:0]  kind;
        logic [2:0]  err;
        logic [15:0] chans;
        logic [15:0] bits;
        logic [31:0] rate;
        logic [7:0]  pcm;
        logic [15:0] lin;
        logic        last;
    } wav_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    wav_riff_parser_mulaw_expand_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    file_byte_t  file_bytes[$];
    logic [7:0]  file_buf[$];
    wav_result_t step_results[$];
    wav_result_t expected_results[$];
    file_byte_t  next_item;

    int fail_count    = 0;
    int bytes_sent    = 0;
    int files_built   = 0;
    int results_seen  = 0;
    int samples_seen  = 0;
    int errors_seen   = 0;
    int cycle_count   = 0;
    logic req_taken   = 1'b0;

    // Parser state mirrored by the bench.
    parse_state_t phase;
    logic [1:0]   byte_idx;
    logic [31:0]  gather;
    logic [31:0]  tag_held;
    logic [31:0]  remaining;
    logic [15:0]  fmt_code;
    logic [15:0]  chans_held;
    logic [31:0]  rate_held;
    logic [15:0]  bits_held;
    logic         fmt_valid;
    logic [1:0]   fmt_idx;

    function automatic logic [15:0] mulaw_to_linear(input logic [7:0] code);
        logic [7:0]  v;
        logic [2:0]  seg;
        logic [31:0] mag;
        v   = ~code;
        seg = v[6:4];
        // Segment bases follow 4 * 33 * (2^seg - 1).
        mag = (((32'd33 << seg) - 32'd33) << 2) + (32'(v[3:0]) << (int'(seg) + 3));
        if (v[7]) begin
            mag = 32'd0 - mag;
        end
        return mag[15:0];
    endfunction

    task parser_reset();
        phase      = AWAIT_RIFF;
        byte_idx   = 2'd0;
        gather     = 32'd0;
        tag_held   = 32'd0;
        remaining  = 32'd0;
        fmt_code   = 16'd0;
        chans_held = 16'd0;
        rate_held  = 32'd0;
        bits_held  = 16'd0;
        fmt_valid  = 1'b0;
        fmt_idx    = 2'd0;
    endtask

    task add_result(input logic [2:0] kind, input logic [2:0] err, input logic [15:0] chans,
                    input logic [15:0] bits, input logic [31:0] rate, input logic [7:0] pcm,
                    input logic [15:0] lin);
        wav_result_t r;
        r.kind  = kind;
        r.err   = err;
        r.chans = chans;
        r.bits  = bits;
        r.rate  = rate;
        r.pcm   = pcm;
        r.lin   = lin;
        r.last  = 1'b0;
        step_results.push_back(r);
    endtask

    task parse_error(input logic [2:0] code);
        add_result(KIND_ERROR, code, 16'd0, 16'd0, 32'd0, 8'd0, 16'd0);
        phase = HALTED;
    endtask

    task parse_word(input logic [31:0] w);
        case (phase)
            AWAIT_RIFF: begin
                if (w != TAG_RIFF) parse_error(ERR_BAD_RIFF);
                else phase = AWAIT_RIFF_SIZE;
            end
            AWAIT_RIFF_SIZE: begin
                phase = AWAIT_WAVE;
            end
            AWAIT_WAVE: begin
                if (w != TAG_WAVE) parse_error(ERR_BAD_WAVE);
                else phase = AWAIT_TAG;
            end
            AWAIT_TAG: begin
                tag_held = w;
                phase    = AWAIT_SIZE;
            end
            AWAIT_SIZE: begin
                if (tag_held == TAG_FMT) begin
                    if (w < 32'd16) begin
                        parse_error(ERR_FMT_SHORT);
                    end else begin
                        remaining = w - 32'd16;
                        fmt_idx   = 2'd0;
                        phase     = IN_FMT;
                    end
                end else if (tag_held == TAG_DATA) begin
                    if (!fmt_valid) begin
                        parse_error(ERR_NO_FMT);
                    end else begin
                        add_result(KIND_FORMAT, ERR_NONE, chans_held, bits_held, rate_held,
                                   8'd0, 16'd0);
                        remaining = w;
                        if (w == 32'd0) begin
                            add_result(KIND_DONE, ERR_NONE, 16'd0, 16'd0, 32'd0, 8'd0, 16'd0);
                            phase = HALTED;
                        end else begin
                            phase = IN_DATA;
                        end
                    end
                end else begin
                    remaining = w;
                    phase     = (w != 32'd0) ? SKIPPING : AWAIT_TAG;
                end
            end
            default: begin
                if (fmt_idx == 2'd0) begin
                    fmt_code   = w[15:0];
                    chans_held = w[31:16];
                end else if (fmt_idx == 2'd1) begin
                    rate_held = w;
                end else if (fmt_idx == 2'd3) begin
                    bits_held = w[31:16];
                    if (fmt_code != FMT_PCM && fmt_code != FMT_MULAW) begin
                        parse_error(ERR_FORMAT);
                        return;
                    end
                    if (fmt_code == FMT_MULAW) bits_held = bits_held << 1;
                    fmt_valid = 1'b1;
                    phase     = (remaining != 32'd0) ? SKIPPING : AWAIT_TAG;
                end
                fmt_idx = fmt_idx + 2'd1;
            end
        endcase
    endtask

    task predict_byte(input logic [7:0] b, input logic eof);
        logic [31:0] w;
        step_results.delete();
        if (phase <= IN_FMT) begin
            gather = gather | (32'(b) << (8 * byte_idx));
            if (byte_idx == 2'd3) begin
                w        = gather;
                byte_idx = 2'd0;
                gather   = 32'd0;
                parse_word(w);
            end else begin
                byte_idx = byte_idx + 2'd1;
            end
        end else if (phase == SKIPPING) begin
            remaining = remaining - 32'd1;
            if (remaining == 32'd0) phase = AWAIT_TAG;
        end else if (phase == IN_DATA) begin
            if (fmt_code == FMT_MULAW)
                add_result(KIND_MULAW, ERR_NONE, 16'd0, 16'd0, 32'd0, 8'd0, mulaw_to_linear(b));
            else
                add_result(KIND_PCM, ERR_NONE, 16'd0, 16'd0, 32'd0, b, 16'd0);
            remaining = remaining - 32'd1;
            if (remaining == 32'd0) begin
                add_result(KIND_DONE, ERR_NONE, 16'd0, 16'd0, 32'd0, 8'd0, 16'd0);
                phase = HALTED;
            end
        end
        if (eof) begin
            if (phase != HALTED && step_results.size() < 2)
                add_result(KIND_ERROR, ERR_TRUNC, 16'd0, 16'd0, 32'd0, 8'd0, 16'd0);
            parser_reset();
        end
        if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
        foreach (step_results[i]) expected_results.push_back(step_results[i]);
    endtask

    task compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    task check_result();
        wav_result_t want;
        if (expected_results.size() == 0) begin
            $error("result of kind %0d arrived with nothing expected", m_tuser);
            fail_count++;
        end else begin
            want = expected_results.pop_front();
            compare_field("result_kind", 32'(want.kind), 32'(m_tuser));
            compare_field("error_code", 32'(want.err), 32'(m_tdata[2:0]));
            compare_field("channel_count", 32'(want.chans), 32'(m_tdata[18:3]));
            compare_field("bits_per_sample", 32'(want.bits), 32'(m_tdata[34:19]));
            compare_field("sample_rate", want.rate, m_tdata[66:35]);
            compare_field("pcm_byte", 32'(want.pcm), 32'(m_tdata[74:67]));
            compare_field("linear_sample", 32'(want.lin), 32'(m_tdata[90:75]));
            compare_field("last_of_run", 32'(want.last), 32'(m_tlast));
        end
        results_seen++;
        if (m_tuser == KIND_MULAW) samples_seen++;
        if (m_tuser == KIND_ERROR) errors_seen++;
    endtask

    // File construction.
    task add_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) file_buf.push_back(w[8*i +: 8]);
    endtask

    task add_half(input logic [15:0] h);
        file_buf.push_back(h[7:0]);
        file_buf.push_back(h[15:8]);
    endtask

    task add_riff_header(input logic [31:0] wave_tag);
        add_word(TAG_RIFF);
        add_word($urandom);
        add_word(wave_tag);
    endtask

    task add_fmt(input logic [31:0] fsize, input logic [15:0] code, input logic [15:0] chans,
                 input logic [31:0] rate, input logic [15:0] bits);
        add_word(TAG_FMT);
        add_word(fsize);
        if (fsize >= 32'd16) begin
            add_half(code);
            add_half(chans);
            add_word(rate);
            add_word($urandom);
            add_half(16'($urandom));
            add_half(bits);
            for (int i = 16; i < int'(fsize); i++) file_buf.push_back(8'($urandom));
        end
    endtask

    task add_chunk(input logic [31:0] tag, input logic [31:0] csize, input int nbytes);
        add_word(tag);
        add_word(csize);
        repeat (nbytes) file_buf.push_back(8'($urandom));
    endtask

    // Queues the file for sending, cut to keep bytes when keep is positive, with the
    // final byte marked as the end of file.
    task close_file(input int keep);
        file_byte_t item;
        if (keep > 0 && keep < file_buf.size()) file_buf = file_buf[0:keep-1];
        if (file_buf.size() == 0) file_buf.push_back(8'($urandom));
        foreach (file_buf[i]) begin
            item.value = file_buf[i];
            item.eof   = (i == file_buf.size() - 1);
            file_bytes.push_back(item);
        end
        file_buf.delete();
        files_built++;
    endtask

    task build_directed_files();
        add_word(32'h5846_4952);
        file_buf.push_back(8'h00);
        close_file(0);

        file_buf.push_back(8'hFF);
        close_file(0);

        add_riff_header(32'h4556_4158);
        close_file(0);

        add_riff_header(TAG_WAVE);
        add_fmt(32'd15, FMT_PCM, 16'd1, 32'd8000, 16'd8);
        close_file(0);

        add_riff_header(TAG_WAVE);
        add_chunk(TAG_DATA, 32'd2, 1);
        close_file(0);

        add_riff_header(TAG_WAVE);
        add_fmt(32'd16, 16'd3, 16'd2, 32'd44100, 16'd32);
        close_file(0);

        add_riff_header(TAG_WAVE);
        add_chunk(32'h7473_696C, 32'd3, 3);
        add_fmt(32'd16, FMT_MULAW, 16'd1, 32'd8000, 16'd8);
        add_fmt(32'd18, FMT_PCM, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        add_word(TAG_DATA);
        add_word(32'd3);
        file_buf.push_back(8'h00);
        file_buf.push_back(8'hFF);
        file_buf.push_back(8'hA5);
        file_buf.push_back(8'h5A);
        file_buf.push_back(8'h00);
        close_file(0);

        add_riff_header(TAG_WAVE);
        add_fmt(32'd16, FMT_MULAW, 16'd0, 32'd0, 16'h8000);
        add_word(TAG_DATA);
        add_word(32'd4);
        file_buf.push_back(8'h00);
        file_buf.push_back(8'hFF);
        file_buf.push_back(8'h7F);
        file_buf.push_back(8'h80);
        close_file(0);

        add_riff_header(TAG_WAVE);
        add_fmt(32'd16, FMT_PCM, 16'd2, 32'd48000, 16'd16);
        add_chunk(TAG_DATA, 32'd0, 0);
        close_file(0);

        add_riff_header(TAG_WAVE);
        add_fmt(32'd16, FMT_MULAW, 16'd1, 32'd8000, 16'd8);
        add_chunk(TAG_DATA, 32'd10, 10);
        close_file(file_buf.size() - 7);
    endtask

    task build_random_file();
        int          shape;
        int          keep;
        int          pick;
        logic [15:0] code;
        logic [31:0] fsize;
        shape = $urandom_range(0, 19);
        keep  = 0;
        if (shape == 0) begin
            repeat ($urandom_range(1, 8)) file_buf.push_back(8'($urandom));
        end else begin
            add_riff_header(TAG_WAVE);
            if (shape == 1) begin
                add_chunk($urandom, $urandom | 32'h100, $urandom_range(0, 6));
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    pick = $urandom_range(0, 5);
                    add_chunk($urandom, 32'(pick), pick);
                end
                if (shape == 2) code = 16'($urandom);
                else code = $urandom_range(0, 1) ? FMT_PCM : FMT_MULAW;
                if (shape == 3) fsize = $urandom_range(0, 15);
                else fsize = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(17, 20)) : 32'd16;
                if (shape != 4) begin
                    add_fmt(fsize, code, 16'($urandom), $urandom,
                            $urandom_range(0, 1) ? 16'($urandom) : 16'd8);
                    if (shape == 5)
                        add_fmt(32'd16, (code == FMT_PCM) ? FMT_MULAW : FMT_PCM,
                                16'($urandom), $urandom, 16'($urandom));
                end
                pick = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 14);
                add_chunk(TAG_DATA, 32'(pick), pick);
                repeat ($urandom_range(0, 3)) file_buf.push_back(8'($urandom));
                if (shape == 6) begin
                    pick = $urandom_range(0, file_buf.size() - 1);
                    file_buf[pick][$urandom_range(0, 7)] ^= 1'b1;
                end
                if (shape == 7) keep = $urandom_range(1, file_buf.size());
            end
        end
        close_file(keep);
    endtask

    // Driver: a new request is offered once the previous one has been taken.
    always @(negedge aclk) begin
        int phase_sel;
        int send_idle;
        int recv_stall;
        phase_sel  = (bytes_sent / PHASE_SPAN) % 4;
        send_idle  = (phase_sel == 1) ? 49 : (phase_sel == 3) ? 19 : 0;
        recv_stall = (phase_sel == 2) ? 49 : (phase_sel == 3) ? 19 : 0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (!s_tvalid || req_taken) begin
                if (file_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                    next_item = file_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_item.value;
                    s_tlast  <= next_item.eof;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    // Model update on each accepted request, then the result check.
    always @(posedge aclk) begin
        if (!aresetn) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                predict_byte(s_tdata, s_tlast);
                bytes_sent++;
            end
            if (m_tvalid && m_tready) check_result();
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int directed_bytes;
        parser_reset();
        build_directed_files();
        directed_bytes = file_bytes.size();
        while (file_bytes.size() < directed_bytes + RANDOM_BYTES) build_random_file();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        while (file_bytes.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            fail_count++;
        end
        $display("Sent %0d files as %0d bytes; checked %0d results.",
                 files_built, bytes_sent, results_seen);
        $display("Among them %0d mu-law samples and %0d parse errors.",
                 samples_seen, errors_seen);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/wrpr_pkg.sv
rtl/wrpr_front.sv
rtl/wrpr_fifo.sv
rtl/wrpr_back.sv
rtl/wav_riff_parser_mulaw_expand_unit.sv
rtl/wrpr_checker.sv
dv/tb_top.sv
